// ===== rtl/chd_pkg.sv =====
// Shared types, byte constants and small decode functions for the chunked
// body decoder. No dependencies.
`default_nettype none

package chd_pkg;

  // Line framing bytes
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Decoder phase codes (code 3 behaves as the size line)
  localparam logic [1:0] PH_SIZE   = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_FOOTER = 2'd2;

  // One result request
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_chunk;
  } res_t;

  // Hex digit decode
  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  // CR/LF pair tracker step
  typedef struct packed {
    logic [1:0] count;
    logic       done;
  } crlf_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = b[3:0];
    if (b inside {[8'h30:8'h39]}) begin
      h.value = b[3:0];
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      h.value = b[3:0] + 4'd9;
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

  // A CR advances an even count, an LF an odd one; anything else restarts.
  // Reaching two means a complete CR LF pair and clears the count.
  function automatic crlf_t crlf_step(input logic [1:0] cnt, input logic [7:0] b);
    crlf_t r;
    logic [1:0] nxt;
    nxt = 2'd0;
    if (b == CH_CR) begin
      nxt = (cnt[0] == 1'b0) ? cnt + 2'd1 : 2'd0;
    end else if (b == CH_LF) begin
      nxt = (cnt[0] == 1'b1) ? cnt + 2'd1 : 2'd0;
    end
    r.done  = (nxt == 2'd2);
    r.count = r.done ? 2'd0 : nxt;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/chd_core.sv =====
// Framing state and per-byte decode: size line, body count and footer skip.
// Depends on chd_pkg.
`default_nettype none

module chd_core import chd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       chunked_enable_i,
  input  wire logic [7:0] byte_i,
  output logic            res_valid_o,
  output res_t            res_o
);

  logic [1:0]           phase_q, phase_d;
  logic [1:0]           crlf_q, crlf_d;
  logic [SIZE_BITS-1:0] remain_q, remain_d;
  logic                 stopped_q, stopped_d;

  hex_t                 hex;
  crlf_t                crlf;
  logic [SIZE_BITS-1:0] remain_dec;
  logic [SIZE_BITS-1:0] remain_acc;

  assign hex        = hex_decode(byte_i);
  assign crlf       = crlf_step(crlf_q, byte_i);
  assign remain_dec = remain_q - {{(SIZE_BITS-1){1'b0}}, 1'b1};
  assign remain_acc = {remain_q[SIZE_BITS-5:0], hex.value};

  // Next state and result for the byte on offer
  always_comb begin
    phase_d       = phase_q;
    crlf_d        = crlf_q;
    remain_d      = remain_q;
    stopped_d     = stopped_q;
    res_valid_o   = 1'b0;
    res_o.out_byte      = byte_i;
    res_o.last_of_chunk = 1'b0;
    if (!chunked_enable_i) begin
      res_valid_o = 1'b1;
    end else begin
      case (phase_q)
        PH_BODY: begin
          remain_d            = remain_dec;
          res_valid_o         = 1'b1;
          res_o.last_of_chunk = (remain_dec == '0);
          if (remain_dec == '0) begin
            phase_d = PH_FOOTER;
          end
        end
        PH_FOOTER: begin
          crlf_d = crlf.count;
          if (crlf.done) begin
            phase_d   = PH_SIZE;
            remain_d  = '0;
            stopped_d = 1'b0;
          end
        end
        default: begin
          // size line: leading hex digits, first other byte stops it
          if (!stopped_q) begin
            if (hex.is_hex) begin
              remain_d = remain_acc;
            end else begin
              stopped_d = 1'b1;
            end
          end
          crlf_d = crlf.count;
          if (crlf.done) begin
            stopped_d = 1'b0;
            phase_d   = (remain_d == '0) ? PH_FOOTER : PH_BODY;
          end
        end
      endcase
    end
  end

  // State registers, updated once per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SIZE;
      crlf_q    <= 2'd0;
      remain_q  <= '0;
      stopped_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      crlf_q    <= crlf_d;
      remain_q  <= remain_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/chd_out_buf.sv =====
// Two-entry output register with skid stage for result requests.
// Depends on chd_pkg.
`default_nettype none

module chd_out_buf import chd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  res_t      push_data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      out_data_o
);

  logic main_valid_q, skid_valid_q;
  res_t main_data_q, skid_data_q;
  logic pop;

  assign pop         = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_data_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_data_q <= skid_data_q;
      end
    end else if (push_i) begin
      if (main_valid_q && !pop) begin
        skid_data_q <= push_data_i;
      end else begin
        main_data_q <= push_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/http_chunked_body_decoder_unit.sv =====
// HTTP chunked decoder: one byte per cycle unless stalled, framing removed.
// An accepted payload byte is registered in the output register or skid stage.
// Throughput: one byte per cycle unless stalled; one framing state update.
// in_stall_o rises only when both output register and skid stage are full.
// Reset clears the framing state, chunked_enable and the output valids.
`default_nettype none

module http_chunked_body_decoder_unit import chd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       chunked_enable_we_i,
  input  wire logic       chunked_enable_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_chunk_o
);

  logic chunked_enable_q;
  logic accept;
  logic res_valid;
  logic buf_full;
  res_t res;
  res_t out_data;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunked_enable_q <= 1'b0;
    end else if (chunked_enable_we_i) begin
      chunked_enable_q <= chunked_enable_i;
    end
  end

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  chd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (accept),
    .chunked_enable_i(chunked_enable_q),
    .byte_i          (in_byte_i),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  chd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && res_valid),
    .push_data_i(res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign out_byte_o      = out_data.out_byte;
  assign last_of_chunk_o = out_data.last_of_chunk;

endmodule

`default_nettype wire
